// ===== design/sdct_pkg.sv =====
// sdct_pkg: shared widths, status codes and pipeline depth for the
// serial date to calendar time converter. No dependencies.
package sdct_pkg;

   localparam int IN_W     = 55;   // serial value width, two's complement
   localparam int DAYS_W   = 22;   // whole days, covers 0 .. 2958465
   localparam int STATUS_W = 2;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;

   // register stages from the whole-day input of sdct_days to its outputs
   localparam int DATE_LAT = 10;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EARLY = 2'd1,
      ST_LATE  = 2'd2
   } status_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } clock_time_type;

endpackage

// ===== design/sdct_days.sv =====
// sdct_days: pipelined day count to proleptic Gregorian year, month, day.
// Uses sdct_pkg. Ten register stages, advanced together by advance.
module sdct_days import sdct_pkg::*; (
   input  logic                clock,
   input  logic                advance,
   input  logic [DAYS_W-1:0]   days,
   output logic [YEAR_W-1:0]   year,
   output logic [MONTH_W-1:0]  month,
   output logic [DAY_W-1:0]    day
);

   localparam int DOE_W = 18;   // day of 400-year era, 0 .. 146096
   localparam int ERA_W = 5;
   localparam int YOE_W = 9;    // year of era, 0 .. 399
   localparam int DOY_W = 9;    // day of March-based year, 0 .. 365
   localparam int MP_W  = 4;
   localparam int NUM_W = 11;   // 5 * doy + 2

   localparam logic [63:0] EPOCH_SHIFT = 64'd693899;   // 0000-03-01 to 1899-12-30
   localparam logic [63:0] ERA_DAYS    = 64'd146097;
   localparam int          ERA_K       = 40;
   localparam int          SMALL_K     = 36;

   // rounded-up reciprocals: exact while operand * divisor < 2^K
   localparam logic [63:0] ERA_RECIP  = ((64'd1 << ERA_K) + ERA_DAYS - 64'd1) / ERA_DAYS;
   localparam logic [63:0] R1460      = ((64'd1 << SMALL_K) + 64'd1459) / 64'd1460;
   localparam logic [63:0] R36524     = ((64'd1 << SMALL_K) + 64'd36523) / 64'd36524;
   localparam logic [63:0] R146096    = ((64'd1 << SMALL_K) + 64'd146095) / 64'd146096;
   localparam logic [63:0] R365       = ((64'd1 << SMALL_K) + 64'd364) / 64'd365;
   localparam logic [63:0] R100       = ((64'd1 << SMALL_K) + 64'd99) / 64'd100;
   localparam logic [63:0] R153       = ((64'd1 << SMALL_K) + 64'd152) / 64'd153;

   // first day of each March-based month: (153 * mp + 2) / 5
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   logic [DAYS_W-1:0]  z1_ff, z2_ff, z_in;
   logic [ERA_W-1:0]   era2_ff, era3_ff, era4_ff, era5_ff, era6_ff, era7_ff, era8_ff, era9_ff;
   logic [ERA_W-1:0]   era_in;
   logic [DOE_W-1:0]   doe3_ff, doe4_ff, doe5_ff, doe6_ff, doe7_ff, doe_in;
   logic [6:0]         q1_ff, q1_in;
   logic [2:0]         q2_ff, q2_in;
   logic               q3_ff, q3_in;
   logic [DOE_W-1:0]   t5_ff, t_in;
   logic [YOE_W-1:0]   yoe6_ff, yoe7_ff, yoe8_ff, yoe9_ff, yoe_in;
   logic [1:0]         c7_ff, c_in;
   logic [DOY_W-1:0]   doy8_ff, doy9_ff, doy_in;
   logic [MP_W-1:0]    mp9_ff, mp_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;

   logic [63:0]        era_prod, q1_prod, q2_prod, q3_prod, yoe_prod, c_prod, mp_prod;
   logic [DOE_W-1:0]   year_base;
   logic [NUM_W-1:0]   mp_num;

   always_comb begin
      z_in     = DAYS_W'(64'(days) + EPOCH_SHIFT);

      era_prod = 64'(z1_ff) * ERA_RECIP;
      era_in   = era_prod[ERA_K +: ERA_W];

      doe_in   = DOE_W'(z2_ff - DAYS_W'(DAYS_W'(era2_ff) * DAYS_W'(ERA_DAYS)));

      q1_prod  = 64'(doe3_ff) * R1460;
      q2_prod  = 64'(doe3_ff) * R36524;
      q3_prod  = 64'(doe3_ff) * R146096;
      q1_in    = q1_prod[SMALL_K +: 7];
      q2_in    = q2_prod[SMALL_K +: 3];
      q3_in    = q3_prod[SMALL_K];

      // leap-day correction before the divide by 365
      t_in     = DOE_W'(doe4_ff - DOE_W'(q1_ff) + DOE_W'(q2_ff) - DOE_W'(q3_ff));

      yoe_prod = 64'(t5_ff) * R365;
      yoe_in   = yoe_prod[SMALL_K +: YOE_W];

      c_prod   = 64'(yoe6_ff) * R100;
      c_in     = c_prod[SMALL_K +: 2];

      year_base = DOE_W'(DOE_W'(yoe7_ff) * DOE_W'(365)) + DOE_W'(yoe7_ff[YOE_W-1:2])
                  - DOE_W'(c7_ff);
      doy_in   = DOY_W'(doe7_ff - year_base);

      mp_num   = NUM_W'(NUM_W'(doy8_ff) * NUM_W'(5)) + NUM_W'(2);
      mp_prod  = 64'(mp_num) * R153;
      mp_in    = mp_prod[SMALL_K +: MP_W];

      // March-based month back to January-based; Jan and Feb belong to next year
      month_in = (mp9_ff < 4'd10) ? MONTH_W'(mp9_ff + 4'd3) : MONTH_W'(mp9_ff - 4'd9);
      year_in  = YEAR_W'(yoe9_ff) + YEAR_W'(YEAR_W'(era9_ff) * YEAR_W'(400))
                 + YEAR_W'(month_in <= 4'd2);
      day_in   = DAY_W'(doy9_ff - month_start(mp9_ff) + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z1_ff    <= z_in;
         era2_ff  <= era_in;
         z2_ff    <= z1_ff;
         doe3_ff  <= doe_in;
         era3_ff  <= era2_ff;
         q1_ff    <= q1_in;
         q2_ff    <= q2_in;
         q3_ff    <= q3_in;
         doe4_ff  <= doe3_ff;
         era4_ff  <= era3_ff;
         t5_ff    <= t_in;
         doe5_ff  <= doe4_ff;
         era5_ff  <= era4_ff;
         yoe6_ff  <= yoe_in;
         doe6_ff  <= doe5_ff;
         era6_ff  <= era5_ff;
         c7_ff    <= c_in;
         yoe7_ff  <= yoe6_ff;
         doe7_ff  <= doe6_ff;
         era7_ff  <= era6_ff;
         doy8_ff  <= doy_in;
         yoe8_ff  <= yoe7_ff;
         era8_ff  <= era7_ff;
         mp9_ff   <= mp_in;
         doy9_ff  <= doy8_ff;
         yoe9_ff  <= yoe8_ff;
         era9_ff  <= era8_ff;
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
      end
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;

endmodule

// ===== design/serial_date_to_calendar_time.sv =====
// serial_date_to_calendar_time: top level, day count with fraction to
// calendar date and rounded time of day. Uses sdct_pkg and sdct_days.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_serial_value (55b signed)
//   rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_year .. rsp_second
//
// One item per cycle while no held result stalls the pipe; rsp_valid rises once
// the item has passed the input stage and the ten stages of the date
// datapath, which set the depth; the time path is shorter and is padded
// to match.
// Synchronous active-high reset clears only the stage valid bits.
// A held result freezes the whole pipe: req_stall rises while rsp_valid is
// high and rsp_stall is high, so nothing is dropped or repeated.
module serial_date_to_calendar_time import sdct_pkg::*; #(
   parameter int FRAC_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [IN_W-1:0] req_serial_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [YEAR_W-1:0]     rsp_year,
   output logic [MONTH_W-1:0]    rsp_month,
   output logic [DAY_W-1:0]      rsp_day,
   output logic [HOUR_W-1:0]     rsp_hour,
   output logic [MIN_W-1:0]      rsp_minute,
   output logic [SEC_W-1:0]      rsp_second
);

   // fraction * 86400 = fraction * 675 * 2^7, so the 2^7 folds into the shift
   localparam int          PROD_W      = FRAC_BITS + 10;
   localparam int          SECS_W      = 17;
   localparam int          SEC_SHIFT   = FRAC_BITS - 7;
   localparam int          MT_W        = 11;            // minutes of day, 0 .. 1439
   localparam logic [63:0] DAY_LIMIT   = 64'd2958466;   // 10000-01-01
   localparam logic [SECS_W-1:0] SECS_PER_DAY = 17'd86400;
   localparam logic [PROD_W-1:0] SEC_SCALE    = PROD_W'(675);
   localparam logic [PROD_W-1:0] HALF_SEC     = PROD_W'(1) << (FRAC_BITS - 8);
   // divide by 60 via reciprocal; exact for operands below 86400
   localparam int          DIV60_K     = 23;
   localparam logic [63:0] DIV60_RECIP = ((64'd1 << DIV60_K) + 64'd59) / 64'd60;
   localparam int          TIME_LAT    = 4;
   localparam int          PAD         = DATE_LAT - TIME_LAT;

   logic                   advance;

   // valid bits, one per stage; stage 0 is the input register
   logic [DATE_LAT:0]      vld_ff;
   status_type             status_ff [0:DATE_LAT];
   status_type             status_in;

   // input stage
   logic [63:0]            whole;
   logic [DAYS_W-1:0]      days_a_ff, days_in;
   logic [PROD_W-1:0]      fprod_a_ff, fprod_in;

   // time of day path
   logic [PROD_W-1:0]      rounded;
   logic [SECS_W-1:0]      secs_raw;
   logic [SECS_W-1:0]      secs1_ff, secs2_ff, secs_in;
   logic [63:0]            mt_prod, hour_prod;
   logic [MT_W-1:0]        mt2_ff, mt3_ff, mt_in;
   logic [HOUR_W-1:0]      hour3_ff, hour_in;
   logic [SEC_W-1:0]       sec3_ff, sec_in;
   logic [MIN_W-1:0]       minute_in;
   clock_time_type         tm_ff [0:PAD];
   clock_time_type         tm_in;

   logic [YEAR_W-1:0]      date_year;
   logic [MONTH_W-1:0]     date_month;
   logic [DAY_W-1:0]       date_day;
   logic                   out_ok;

   // whole pipe moves unless a finished item sits at the output and is held
   assign advance   = !(vld_ff[DATE_LAT] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[DATE_LAT];

   // classify on the raw input: sign bit first, then the whole-day limit
   always_comb begin
      whole    = 64'(req_serial_value[IN_W-1:FRAC_BITS]);
      days_in  = whole[DAYS_W-1:0];
      fprod_in = PROD_W'(req_serial_value[FRAC_BITS-1:0]) * SEC_SCALE;
      if (req_serial_value[IN_W-1]) begin
         status_in = ST_EARLY;
      end else if (whole >= DAY_LIMIT) begin
         status_in = ST_LATE;
      end else begin
         status_in = ST_OK;
      end
   end

   // seconds of day, round half up; a full 86400 wraps to midnight of the
   // same date (the date is not carried)
   always_comb begin
      rounded   = fprod_a_ff + HALF_SEC;
      secs_raw  = rounded[PROD_W-1:SEC_SHIFT];
      secs_in   = (secs_raw >= SECS_PER_DAY) ? '0 : secs_raw;

      mt_prod   = 64'(secs1_ff) * DIV60_RECIP;
      mt_in     = mt_prod[DIV60_K +: MT_W];

      sec_in    = SEC_W'(secs2_ff - SECS_W'(SECS_W'(mt2_ff) * SECS_W'(60)));
      hour_prod = 64'(mt2_ff) * DIV60_RECIP;
      hour_in   = hour_prod[DIV60_K +: HOUR_W];

      minute_in = MIN_W'(mt3_ff - MT_W'(MT_W'(hour3_ff) * MT_W'(60)));
      tm_in     = '{hour: hour3_ff, minute: minute_in, second: sec3_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DATE_LAT-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         days_a_ff    <= days_in;
         fprod_a_ff   <= fprod_in;
         status_ff[0] <= status_in;
         for (int i = 1; i <= DATE_LAT; i++) begin
            status_ff[i] <= status_ff[i-1];
         end
         secs1_ff     <= secs_in;
         secs2_ff     <= secs1_ff;
         mt2_ff       <= mt_in;
         mt3_ff       <= mt2_ff;
         hour3_ff     <= hour_in;
         sec3_ff      <= sec_in;
         tm_ff[0]     <= tm_in;
         for (int i = 1; i <= PAD; i++) begin
            tm_ff[i] <= tm_ff[i-1];
         end
      end
   end

   sdct_days u_days (
      .clock   (clock),
      .advance (advance),
      .days    (days_a_ff),
      .year    (date_year),
      .month   (date_month),
      .day     (date_day)
   );

   // null result: every field but status reads zero
   assign out_ok     = (status_ff[DATE_LAT] == ST_OK);
   assign rsp_status = status_ff[DATE_LAT];
   assign rsp_year   = out_ok ? date_year  : '0;
   assign rsp_month  = out_ok ? date_month : '0;
   assign rsp_day    = out_ok ? date_day   : '0;
   assign rsp_hour   = out_ok ? tm_ff[PAD].hour   : '0;
   assign rsp_minute = out_ok ? tm_ff[PAD].minute : '0;
   assign rsp_second = out_ok ? tm_ff[PAD].second : '0;

   a_freeze_on_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while output was held");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |->
         (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_day <= 5'd31
          && rsp_year >= 14'd1899 && rsp_year <= 14'd9999))
      else $error("calendar date out of range on a valid result");

   a_null_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_year == '0 && rsp_month == '0 && rsp_day == '0
          && rsp_hour == '0 && rsp_minute == '0 && rsp_second == '0))
      else $error("null result carries nonzero fields");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time of day out of range");

endmodule
